>>> hw/rtl/scm_pkg.sv
`default_nettype none

package scm_pkg;

   // internal operation codes, set by the front end
   localparam logic [2:0] OP_SAMPLE = 3'd0;
   localparam logic [2:0] OP_FAULT  = 3'd1;
   localparam logic [2:0] OP_LIMITS = 3'd2;
   localparam logic [2:0] OP_RANGE  = 3'd3;
   localparam logic [2:0] OP_TICK   = 3'd4;
   localparam logic [2:0] OP_NOP    = 3'd5;

   // func field codes
   localparam logic [1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [1:0] FUNC_LIMITS = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FAULT = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_GAIN     = 2'd0;
   localparam logic [1:0] CSR_BIAS     = 2'd1;
   localparam logic [1:0] CSR_CHANNELS = 2'd2;

   // alarm bit positions
   localparam int ALM_LOW   = 0;
   localparam int ALM_HIGH  = 1;
   localparam int ALM_CRIT  = 2;
   localparam int ALM_FAULT = 3;

   localparam logic [4:0] CHANNELS_RESET = 5'd16;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  channel;
      logic [31:0] value;
      logic [31:0] limit_lo;
      logic [31:0] limit_hi;
      logic [31:0] limit_crit;
   } cmd_type;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] min_val;
      logic [31:0] max_val;
      logic [3:0]  alarms;
      logic        valid;
      logic [31:0] stamp;
      logic [31:0] limit_lo;
      logic [31:0] limit_hi;
      logic [31:0] limit_crit;
   } row_type;

   // handshake between front end and queue, and queue and back end
   typedef struct packed {
      logic push;
      logic full;
   } push_ctl_type;

   typedef struct packed {
      logic pop;
      logic empty;
   } pop_ctl_type;

endpackage

`default_nettype wire

>>> hw/rtl/scm_req_if.sv
`default_nettype none

interface scm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [3:0]  channel;
   logic [31:0] raw_reading;
   logic        read_fault;
   logic [31:0] new_low_limit;
   logic [31:0] new_high_limit;
   logic [31:0] new_crit_limit;

   modport source (
      output valid, func, channel, raw_reading, read_fault,
             new_low_limit, new_high_limit, new_crit_limit,
      input  ready
   );
   modport sink (
      input  valid, func, channel, raw_reading, read_fault,
             new_low_limit, new_high_limit, new_crit_limit,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/scm_rsp_if.sv
`default_nettype none

interface scm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  out_channel;
   logic [31:0] scaled_value;
   logic [31:0] lowest_seen;
   logic [31:0] highest_seen;
   logic [3:0]  alarm_bits;
   logic        reading_valid;
   logic [31:0] stamp;

   modport source (
      output valid, status, out_channel, scaled_value, lowest_seen,
             highest_seen, alarm_bits, reading_valid, stamp,
      input  ready
   );
   modport sink (
      input  valid, status, out_channel, scaled_value, lowest_seen,
             highest_seen, alarm_bits, reading_valid, stamp,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/scm_csr_if.sv
`default_nettype none

interface scm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/scm_front.sv
`default_nettype none

module scm_front #(
   parameter int CHANNELS = 16
) (
   input  wire                       clock,
   input  wire                       reset,
   scm_req_if.sink                   req,
   scm_csr_if.sink                   csr,
   output scm_pkg::push_ctl_type     push_ctl,
   input  wire                       queue_full,
   output scm_pkg::cmd_type          push_cmd
);

   logic [15:0]      gain_ff;
   logic [31:0]      bias_ff;
   logic [4:0]       chan_use_ff;

   logic             stage_valid_ff;
   logic             stage_valid_in;
   scm_pkg::cmd_type stage_cmd_ff;
   scm_pkg::cmd_type stage_cmd_in;

   logic             accept;
   logic             push;
   logic             out_of_range;
   logic [31:0]      gain_ext;

   // configuration registers
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= 16'd1;
         bias_ff     <= '0;
         chan_use_ff <= scm_pkg::CHANNELS_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            scm_pkg::CSR_GAIN:     gain_ff     <= csr.data[15:0];
            scm_pkg::CSR_BIAS:     bias_ff     <= csr.data;
            scm_pkg::CSR_CHANNELS: chan_use_ff <= csr.data[4:0];
            default: ;
         endcase
      end
   end

   // classify and scale
   assign out_of_range = ({1'b0, req.channel} >= chan_use_ff) ||
                         (32'(req.channel) >= 32'(CHANNELS));
   assign gain_ext     = {{16{gain_ff[15]}}, gain_ff};

   always_comb begin
      stage_cmd_in            = '0;
      stage_cmd_in.channel    = req.channel;
      stage_cmd_in.value      = req.raw_reading * gain_ext;
      stage_cmd_in.limit_lo   = req.new_low_limit;
      stage_cmd_in.limit_hi   = req.new_high_limit;
      stage_cmd_in.limit_crit = req.new_crit_limit;
      priority if (req.func == scm_pkg::FUNC_TICK) begin
         stage_cmd_in.op = scm_pkg::OP_TICK;
      end else if (req.func != scm_pkg::FUNC_SAMPLE && req.func != scm_pkg::FUNC_LIMITS) begin
         stage_cmd_in.op = scm_pkg::OP_NOP;
      end else if (out_of_range) begin
         stage_cmd_in.op = scm_pkg::OP_RANGE;
      end else if (req.func == scm_pkg::FUNC_LIMITS) begin
         stage_cmd_in.op = scm_pkg::OP_LIMITS;
      end else if (req.read_fault) begin
         stage_cmd_in.op = scm_pkg::OP_FAULT;
      end else begin
         stage_cmd_in.op = scm_pkg::OP_SAMPLE;
      end
   end

   assign push      = stage_valid_ff && !queue_full;
   assign req.ready = !stage_valid_ff || !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_cmd_ff <= stage_cmd_in;
      end
   end

   // offset added on the way into the queue
   always_comb begin
      push_cmd       = stage_cmd_ff;
      push_cmd.value = stage_cmd_ff.value + bias_ff;
   end

   assign push_ctl.push = push;
   assign push_ctl.full = queue_full;

endmodule

`default_nettype wire

>>> hw/rtl/scm_queue.sv
`default_nettype none

module scm_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  scm_pkg::push_ctl_type push_ctl,
   input  scm_pkg::cmd_type      push_cmd,
   output logic                  full,
   input  wire                   pop,
   output scm_pkg::pop_ctl_type  pop_ctl,
   output scm_pkg::cmd_type      pop_cmd
);

   scm_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == 2'd2);
   assign do_push = push_ctl.push && !push_ctl.full;
   assign do_pop  = pop && (count_ff != 2'd0);

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd       = slot_ff[rd_ptr_ff];
   assign pop_ctl.pop   = do_pop;
   assign pop_ctl.empty = (count_ff == 2'd0);

endmodule

`default_nettype wire

>>> hw/rtl/scm_back.sv
`default_nettype none

module scm_back #(
   parameter int CHANNELS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  scm_pkg::pop_ctl_type pop_ctl,
   input  scm_pkg::cmd_type     pop_cmd,
   output logic                 pop,
   scm_rsp_if.source            rsp
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]       state_ff;
   logic [1:0]       state_in;
   scm_pkg::cmd_type cmd_ff;
   logic [31:0]      tick_ff;
   logic [31:0]      tick_in;

   scm_pkg::row_type row_mem_ff [CHANNELS];
   logic [CHANNELS-1:0] row_ok_ff;
   scm_pkg::row_type rd_row_ff;
   logic             rd_ok_ff;

   logic [IDX_W-1:0] idx;
   scm_pkg::row_type row;
   scm_pkg::row_type new_row;
   logic             row_write;
   logic             out_free;
   logic             finish;

   logic             rsp_valid_ff;
   logic [1:0]       status_ff;
   logic [3:0]       out_channel_ff;
   scm_pkg::row_type res_row_ff;
   logic [1:0]       status_in;
   logic [3:0]       out_channel_in;
   scm_pkg::row_type res_row_in;

   assign idx      = IDX_W'(cmd_ff.channel);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign pop      = (state_ff == ST_IDLE) && !pop_ctl.empty;
   assign finish   = (state_ff == ST_EXEC) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (pop) state_in = ST_READ;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // table read, an entry never written reads as zero
   always_ff @(posedge clock) begin
      rd_row_ff <= row_mem_ff[idx];
      rd_ok_ff  <= row_ok_ff[idx];
   end

   assign row = rd_ok_ff ? rd_row_ff : '0;

   always_comb begin
      new_row        = row;
      row_write      = 1'b0;
      tick_in        = tick_ff;
      status_in      = scm_pkg::STATUS_OK;
      out_channel_in = cmd_ff.channel;
      res_row_in     = '0;
      unique case (cmd_ff.op)
         scm_pkg::OP_TICK: begin
            tick_in          = tick_ff + 32'd1;
            out_channel_in   = '0;
            res_row_in.stamp = tick_ff + 32'd1;
         end
         scm_pkg::OP_NOP: begin
            out_channel_in   = '0;
            res_row_in.stamp = tick_ff;
         end
         scm_pkg::OP_RANGE: begin
            status_in = scm_pkg::STATUS_RANGE;
         end
         scm_pkg::OP_LIMITS: begin
            new_row.limit_lo   = cmd_ff.limit_lo;
            new_row.limit_hi   = cmd_ff.limit_hi;
            new_row.limit_crit = cmd_ff.limit_crit;
            row_write          = 1'b1;
            res_row_in         = new_row;
         end
         scm_pkg::OP_FAULT: begin
            new_row.valid                     = 1'b0;
            new_row.alarms[scm_pkg::ALM_FAULT] = 1'b1;
            row_write                         = 1'b1;
            status_in                         = scm_pkg::STATUS_FAULT;
            res_row_in                        = new_row;
         end
         scm_pkg::OP_SAMPLE: begin
            new_row.value = cmd_ff.value;
            new_row.stamp = tick_ff;
            new_row.valid = 1'b1;
            if ($signed(cmd_ff.value) < $signed(row.min_val) || row.min_val == '0) begin
               new_row.min_val = cmd_ff.value;
            end
            if ($signed(row.max_val) < $signed(cmd_ff.value)) begin
               new_row.max_val = cmd_ff.value;
            end
            new_row.alarms = '0;
            new_row.alarms[scm_pkg::ALM_LOW] = (row.limit_lo != '0) &&
               ($signed(cmd_ff.value) < $signed(row.limit_lo));
            new_row.alarms[scm_pkg::ALM_HIGH] = (row.limit_hi != '0) &&
               ($signed(row.limit_hi) < $signed(cmd_ff.value));
            new_row.alarms[scm_pkg::ALM_CRIT] = (row.limit_crit != '0) &&
               ($signed(row.limit_crit) < $signed(cmd_ff.value));
            row_write  = 1'b1;
            res_row_in = new_row;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (finish && row_write) begin
         row_mem_ff[idx] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         row_ok_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            tick_ff <= tick_in;
            if (row_write) begin
               row_ok_ff[idx] <= 1'b1;
            end
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ctl.pop) begin
         cmd_ff <= pop_cmd;
      end
      if (finish) begin
         status_ff      <= status_in;
         out_channel_ff <= out_channel_in;
         res_row_ff     <= res_row_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.out_channel   = out_channel_ff;
   assign rsp.scaled_value  = res_row_ff.value;
   assign rsp.lowest_seen   = res_row_ff.min_val;
   assign rsp.highest_seen  = res_row_ff.max_val;
   assign rsp.alarm_bits    = res_row_ff.alarms;
   assign rsp.reading_valid = res_row_ff.valid;
   assign rsp.stamp         = res_row_ff.stamp;

endmodule

`default_nettype wire

>>> hw/rtl/sensor_channel_monitor_top.sv
// multi-channel sensor monitor: each sample item is scaled as raw * gain + bias
// (32-bit wrap), stored with the current tick stamp, tracked for min and max and
// checked against the channel's low, high and critical limits (zero disables a
// limit); a limits item sets one channel's limits and a tick item advances the
// stamp counter. every item yields exactly one result item. the front end takes
// one item per cycle into a two-entry queue while the queue has room; the back
// end pops an item only when done with the last (queue pop, table read, update
// and write-back through the single-port channel table). the channel table needs
// no clearing pass after reset: a per-channel written bit makes untouched entries
// read as zero. the user writes gain, bias and the number of channels in use
// through the csr channel while the block is idle; the block does not check it.
`default_nettype none

module sensor_channel_monitor_top #(
   parameter int CHANNELS = 16
) (
   input  wire        clock,
   input  wire        reset,
   scm_req_if.sink    req_chan,
   scm_rsp_if.source  rsp_chan,
   scm_csr_if.sink    csr_chan
);

   // front end to queue
   scm_pkg::push_ctl_type push_ctl;
   scm_pkg::cmd_type      push_cmd;
   logic                  queue_full;

   // queue to back end
   scm_pkg::pop_ctl_type  pop_ctl;
   scm_pkg::cmd_type      pop_cmd;
   logic                  pop;

   // decode, config registers and scaling multiply
   scm_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr        (csr_chan),
      .push_ctl   (push_ctl),
      .queue_full (queue_full),
      .push_cmd   (push_cmd)
   );

   // decouples item intake from table updates
   scm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_ctl (push_ctl),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .pop_ctl  (pop_ctl),
      .pop_cmd  (pop_cmd)
   );

   // channel table read-modify-write, tick counter and result register
   scm_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .pop_ctl (pop_ctl),
      .pop_cmd (pop_cmd),
      .pop     (pop),
      .rsp     (rsp_chan)
   );

endmodule

`default_nettype wire
